// ===== hdl/cogu_pkg.sv =====
// Shared types, constants and tables of the occupancy grid update core.
// Used by the CORDIC, the top level and the testbench; depends on nothing.
package cogu_pkg;

  localparam int GRID_CELLS   = 128;
  localparam int WINDOW_CELLS = 10;
  localparam int MEM_DEPTH    = GRID_CELLS * GRID_CELLS;
  localparam int ADDR_W       = $clog2(MEM_DEPTH);
  localparam int IDX_W        = $clog2(GRID_CELLS);
  localparam int WIN_W        = (WINDOW_CELLS > 2) ? $clog2(WINDOW_CELLS) : 1;
  localparam int CEN_W        = IDX_W + 11;
  localparam int DX_W         = CEN_W + 2;
  localparam int CW           = DX_W + 15;
  localparam int ZW           = 22;
  localparam int SQ_W         = 2 * DX_W;
  localparam int D2_W         = SQ_W + 1;
  localparam int POS_W        = 17;
  localparam int ACC_W        = 32;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int INV_GAIN_Q14 = 9949;
  localparam int HALF_TURN_Z  = 524288;

  localparam logic signed [16:0] LOG_FREE = -17'sd217;
  localparam logic signed [16:0] LOG_OCC  = 17'sd217;

  localparam logic [2:0] REG_ROBOT_X   = 3'd0;
  localparam logic [2:0] REG_ROBOT_Y   = 3'd1;
  localparam logic [2:0] REG_HEADING   = 3'd2;
  localparam logic [2:0] REG_OFFSET_X  = 3'd3;
  localparam logic [2:0] REG_OFFSET_Y  = 3'd4;
  localparam logic [2:0] REG_CELL_SIZE = 3'd5;
  localparam logic [2:0] REG_WALL      = 3'd6;
  localparam logic [2:0] REG_TOL       = 3'd7;

  typedef struct packed {
    logic        func;
    logic [13:0] range_mm;
    logic [15:0] scan_bearing;
    logic [6:0]  cell_x;
    logic [6:0]  cell_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] cell_value;
    logic [6:0]         cells_updated;
    logic               off_grid;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic                 vec;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                 busy;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_rsp_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_ROT, ST_ROTW, ST_OFS0, ST_OFS1, ST_OFS2, ST_OFS3,
    ST_SQ0, ST_SQ1, ST_CELL, ST_VEC, ST_VECW, ST_BEAR, ST_DIST, ST_UPD,
    ST_NEXT, ST_DONE
  } state_e;

  function automatic logic signed [ZW-1:0] atan_of(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      4'd0:    r = 22'sd131072;
      4'd1:    r = 22'sd77376;
      4'd2:    r = 22'sd40884;
      4'd3:    r = 22'sd20753;
      4'd4:    r = 22'sd10417;
      4'd5:    r = 22'sd5213;
      4'd6:    r = 22'sd2607;
      4'd7:    r = 22'sd1304;
      4'd8:    r = 22'sd652;
      4'd9:    r = 22'sd326;
      4'd10:   r = 22'sd163;
      4'd11:   r = 22'sd81;
      4'd12:   r = 22'sd41;
      4'd13:   r = 22'sd20;
      4'd14:   r = 22'sd10;
      default: r = 22'sd5;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/cogu_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module cogu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hdl/cogu_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, in rotation or vectoring mode.
// Depends on cogu_pkg for widths, request and response types and the atan table.
module cogu_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cogu_pkg::cordic_req_t req_i,
  output cogu_pkg::cordic_rsp_t rsp_o
);

  logic                           busy_q;
  logic [cogu_pkg::STEP_W-1:0]    it_q;
  logic                           vec_q;
  logic signed [cogu_pkg::CW-1:0] x_q, y_q, tx, ty;
  logic signed [cogu_pkg::ZW-1:0] z_q, at;
  logic                           cw;

  always_comb begin
    tx = x_q >>> it_q;
    ty = y_q >>> it_q;
    at = cogu_pkg::atan_of(it_q);
    cw = vec_q ? (y_q > 0) : z_q[cogu_pkg::ZW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      it_q   <= '0;
    end else if (busy_q) begin
      it_q <= it_q + 1'b1;
      if (it_q == cogu_pkg::STEP_W'(cogu_pkg::CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      vec_q <= req_i.vec;
      x_q   <= req_i.x;
      y_q   <= req_i.y;
      z_q   <= req_i.z;
    end else if (busy_q) begin
      if (cw) begin
        x_q <= x_q + ty;
        y_q <= y_q - tx;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ty;
        y_q <= y_q + tx;
        z_q <= z_q - at;
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.x    = x_q;
  assign rsp_o.y    = y_q;
  assign rsp_o.z    = z_q;

endmodule

// ===== hdl/occupancy_grid_log_odds_update_core.sv =====
// Top level of the log-odds occupancy grid update core: sequencer and datapath.
// Depends on cogu_pkg, cogu_ram and cogu_cordic.
//
// Items enter on in_valid_i/in_ready_o and results leave on out_valid_o/out_ready_i.
// Every item gives exactly one result. A read item (func 1) returns one grid cell: the
// cell is read as the item is accepted and the result is registered from the done state
// once the output register is free. A scan item (func 0) first computes the sensor pose
// and the window origin, with the 16-step rotation CORDIC and the cell-index divider
// running side by side. It then visits the window of cells around the robot one at a
// time. A cell off the grid goes straight on to the next cell; a cell on the grid goes
// through the 16-step vectoring CORDIC and the beam check, and a cell in the beam is
// checked for distance and written back by a read-modify-write of the grid memory if
// its value changes. The window is 10 by 10 cells. One item is worked on at a time; the
// next item is taken as soon as the result sits in the output register, even if the
// receiver stalls. After reset the grid memory is cleared one cell per cycle, all 16384
// cells, and no item is accepted meanwhile; configuration writes are taken at any time.
module occupancy_grid_log_odds_update_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cogu_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cogu_pkg::out_item_t out_data_o
);

  localparam int DX_W  = cogu_pkg::DX_W;
  localparam int CW    = cogu_pkg::CW;
  localparam int ZW    = cogu_pkg::ZW;
  localparam int AW    = cogu_pkg::ADDR_W;
  localparam int IW    = cogu_pkg::IDX_W;
  localparam int WW    = cogu_pkg::WIN_W;
  localparam int PW    = cogu_pkg::POS_W;
  localparam int ACC_W = cogu_pkg::ACC_W;

  logic [14:0]        rx_q, ry_q;
  logic [15:0]        hd_q;
  logic signed [11:0] ox_q, oy_q;
  logic [9:0]         cell_q, wall_q, cell_eff;
  logic [13:0]        tol_q;

  cogu_pkg::state_e state_q, state_d;

  logic [AW-1:0]         clr_q, addr_q, rd_addr, wr_addr;
  logic                  func_q, rdok_q;
  logic [13:0]           range_q;
  logic [15:0]           beam_q;
  logic [14:0]           nx_q, ny_q, qx_q, qy_q;
  logic [9:0]            remx_q, remy_q;
  logic [3:0]            dcnt_q;
  logic [10:0]           trial_x, trial_y;
  logic                  ge_x, ge_y;
  logic signed [ACC_W-1:0] acc_q, t_ofs;
  logic signed [17:0]    sx_q, sy_q, c_s, s_s;
  logic [33:0]           free2_q, occ2_q;
  logic signed [16:0]    fr, oc;
  logic signed [PW-1:0]  col0_q, row0_q, col_s, row_s;
  logic [WW-1:0]         wi_q, wj_q;
  logic                  in_grid;
  logic [cogu_pkg::CEN_W-1:0] cen_x, cen_y;
  logic signed [DX_W-1:0] dx_q, dy_q;
  logic                  zero_q, dzero;
  logic [cogu_pkg::SQ_W-1:0] sq_q;
  logic [cogu_pkg::D2_W-1:0] d2_q;
  logic [ZW-1:0]         zs;
  logic [15:0]           bear, diff, mag;
  logic                  in_beam;
  logic signed [15:0]    cur;
  logic signed [16:0]    sum;
  logic signed [15:0]    sat;
  logic                  hit_free, hit_occ, hit, chg;
  logic [6:0]            cnt_q;
  logic                  off_q;
  logic                  out_valid_q;
  cogu_pkg::out_item_t   out_q;
  logic                  accept, out_free, ram_we, ram_re, last_cell;
  logic [15:0]           rdata;
  logic signed [CW-1:0]  vx0, vy0;
  cogu_pkg::cordic_req_t creq;
  cogu_pkg::cordic_rsp_t crsp;

  assign cell_eff = (cell_q == '0) ? 10'd1 : cell_q;
  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == cogu_pkg::ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q   <= 15'd50;
      ry_q   <= 15'd50;
      hd_q   <= 16'd16384;
      ox_q   <= 12'sd0;
      oy_q   <= 12'sd100;
      cell_q <= 10'd100;
      wall_q <= 10'd50;
      tol_q  <= 14'd728;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cogu_pkg::REG_ROBOT_X:   rx_q   <= cfg_data_i[14:0];
        cogu_pkg::REG_ROBOT_Y:   ry_q   <= cfg_data_i[14:0];
        cogu_pkg::REG_HEADING:   hd_q   <= cfg_data_i;
        cogu_pkg::REG_OFFSET_X:  ox_q   <= $signed(cfg_data_i[11:0]);
        cogu_pkg::REG_OFFSET_Y:  oy_q   <= $signed(cfg_data_i[11:0]);
        cogu_pkg::REG_CELL_SIZE: cell_q <= cfg_data_i[9:0];
        cogu_pkg::REG_WALL:      wall_q <= cfg_data_i[9:0];
        cogu_pkg::REG_TOL:       tol_q  <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    trial_x = {remx_q, nx_q[14]};
    trial_y = {remy_q, ny_q[14]};
    ge_x    = trial_x >= {1'b0, cell_eff};
    ge_y    = trial_y >= {1'b0, cell_eff};

    case (hd_q[15:14])
      2'd0:    begin c_s = crsp.x[17:0];  s_s = crsp.y[17:0];  end
      2'd1:    begin c_s = -crsp.y[17:0]; s_s = crsp.x[17:0];  end
      2'd2:    begin c_s = -crsp.x[17:0]; s_s = -crsp.y[17:0]; end
      default: begin c_s = crsp.y[17:0];  s_s = -crsp.x[17:0]; end
    endcase

    case (state_q)
      cogu_pkg::ST_OFS1: t_ofs = acc_q - ACC_W'(oy_q) * ACC_W'(s_s) + ACC_W'(4096);
      default:           t_ofs = acc_q + ACC_W'(oy_q) * ACC_W'(c_s) + ACC_W'(4096);
    endcase

    fr = $signed({2'b00, range_q, 1'b0}) - $signed({7'd0, wall_q});
    oc = $signed({2'b00, range_q, 1'b0}) + $signed({7'd0, wall_q});

    col_s   = col0_q + $signed(PW'(wj_q));
    row_s   = row0_q + $signed(PW'(wi_q));
    in_grid = (col_s >= 0) && (col_s < cogu_pkg::GRID_CELLS) &&
              (row_s >= 0) && (row_s < cogu_pkg::GRID_CELLS);
    cen_x   = cogu_pkg::CEN_W'({col_s[IW-1:0], 1'b1}) * cogu_pkg::CEN_W'(cell_eff);
    cen_y   = cogu_pkg::CEN_W'({row_s[IW-1:0], 1'b1}) * cogu_pkg::CEN_W'(cell_eff);

    dzero = (dx_q == '0) && (dy_q == '0);
    vx0   = CW'($signed({dx_q, 12'd0}));
    vy0   = CW'($signed({dy_q, 12'd0}));

    creq.start = 1'b0;
    creq.vec   = 1'b0;
    creq.x     = CW'(cogu_pkg::INV_GAIN_Q14);
    creq.y     = '0;
    creq.z     = $signed(ZW'({hd_q[13:0], 4'd0}));
    if (state_q == cogu_pkg::ST_ROT) begin
      creq.start = 1'b1;
    end else if (state_q == cogu_pkg::ST_VEC) begin
      creq.start = !dzero;
      creq.vec   = 1'b1;
      if (dx_q < 0) begin
        creq.x = -vx0;
        creq.y = -vy0;
        creq.z = ZW'(cogu_pkg::HALF_TURN_Z);
      end else begin
        creq.x = vx0;
        creq.y = vy0;
        creq.z = '0;
      end
    end

    zs      = crsp.z + ZW'(8);
    bear    = zero_q ? 16'd0 : zs[19:4];
    diff    = bear - beam_q;
    mag     = diff[15] ? (16'd0 - diff) : diff;
    in_beam = mag < {2'b00, tol_q};

    cur      = $signed(rdata);
    hit_free = d2_q < cogu_pkg::D2_W'(free2_q);
    hit_occ  = d2_q < cogu_pkg::D2_W'(occ2_q);
    hit      = hit_free || hit_occ;
    sum      = 17'(cur) + (hit_free ? cogu_pkg::LOG_FREE : cogu_pkg::LOG_OCC);
    if (sum > 17'sd32767) begin
      sat = 16'sd32767;
    end else if (sum < -17'sd32768) begin
      sat = -16'sd32768;
    end else begin
      sat = sum[15:0];
    end
    chg = hit && (sat != cur);

    last_cell = (wi_q == WW'(cogu_pkg::WINDOW_CELLS - 1)) &&
                (wj_q == WW'(cogu_pkg::WINDOW_CELLS - 1));

    ram_re  = (accept && in_data_i.func) || (state_q == cogu_pkg::ST_CELL);
    rd_addr = (state_q == cogu_pkg::ST_CELL)
            ? AW'(AW'(row_s[IW-1:0]) * AW'(cogu_pkg::GRID_CELLS) + AW'(col_s[IW-1:0]))
            : AW'(AW'(in_data_i.cell_y) * AW'(cogu_pkg::GRID_CELLS) + AW'(in_data_i.cell_x));
    ram_we  = (state_q == cogu_pkg::ST_CLR) || ((state_q == cogu_pkg::ST_UPD) && chg);
    wr_addr = (state_q == cogu_pkg::ST_CLR) ? clr_q : addr_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cogu_pkg::ST_CLR:  if (clr_q == AW'(cogu_pkg::MEM_DEPTH - 1)) state_d = cogu_pkg::ST_IDLE;
      cogu_pkg::ST_IDLE: begin
        if (accept) state_d = in_data_i.func ? cogu_pkg::ST_DONE : cogu_pkg::ST_ROT;
      end
      cogu_pkg::ST_ROT:  state_d = cogu_pkg::ST_ROTW;
      cogu_pkg::ST_ROTW: if (!crsp.busy && dcnt_q == '0) state_d = cogu_pkg::ST_OFS0;
      cogu_pkg::ST_OFS0: state_d = cogu_pkg::ST_OFS1;
      cogu_pkg::ST_OFS1: state_d = cogu_pkg::ST_OFS2;
      cogu_pkg::ST_OFS2: state_d = cogu_pkg::ST_OFS3;
      cogu_pkg::ST_OFS3: state_d = cogu_pkg::ST_SQ0;
      cogu_pkg::ST_SQ0:  state_d = cogu_pkg::ST_SQ1;
      cogu_pkg::ST_SQ1:  state_d = cogu_pkg::ST_CELL;
      cogu_pkg::ST_CELL: state_d = in_grid ? cogu_pkg::ST_VEC : cogu_pkg::ST_NEXT;
      cogu_pkg::ST_VEC:  state_d = dzero ? cogu_pkg::ST_BEAR : cogu_pkg::ST_VECW;
      cogu_pkg::ST_VECW: if (!crsp.busy) state_d = cogu_pkg::ST_BEAR;
      cogu_pkg::ST_BEAR: state_d = in_beam ? cogu_pkg::ST_DIST : cogu_pkg::ST_NEXT;
      cogu_pkg::ST_DIST: state_d = cogu_pkg::ST_UPD;
      cogu_pkg::ST_UPD:  state_d = cogu_pkg::ST_NEXT;
      cogu_pkg::ST_NEXT: state_d = last_cell ? cogu_pkg::ST_DONE : cogu_pkg::ST_CELL;
      cogu_pkg::ST_DONE: if (out_free) state_d = cogu_pkg::ST_IDLE;
      default:           state_d = cogu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cogu_pkg::ST_CLR;
      clr_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == cogu_pkg::ST_CLR) clr_q <= clr_q + 1'b1;
      if (accept && !in_data_i.func) begin
        dcnt_q <= 4'd15;
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (state_q == cogu_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= in_data_i.func;
      range_q <= in_data_i.range_mm;
      beam_q  <= hd_q + in_data_i.scan_bearing;
      rdok_q  <= (32'(in_data_i.cell_x) < cogu_pkg::GRID_CELLS) &&
                 (32'(in_data_i.cell_y) < cogu_pkg::GRID_CELLS);
      nx_q    <= rx_q;
      ny_q    <= ry_q;
      remx_q  <= '0;
      remy_q  <= '0;
      qx_q    <= '0;
      qy_q    <= '0;
    end else if (dcnt_q != '0) begin
      nx_q   <= {nx_q[13:0], 1'b0};
      ny_q   <= {ny_q[13:0], 1'b0};
      remx_q <= ge_x ? 10'(trial_x - {1'b0, cell_eff}) : trial_x[9:0];
      remy_q <= ge_y ? 10'(trial_y - {1'b0, cell_eff}) : trial_y[9:0];
      qx_q   <= {qx_q[13:0], ge_x};
      qy_q   <= {qy_q[13:0], ge_y};
    end

    case (state_q)
      cogu_pkg::ST_OFS0: begin
        acc_q  <= ACC_W'(ox_q) * ACC_W'(c_s);
        col0_q <= $signed({2'b00, qx_q}) - PW'(cogu_pkg::WINDOW_CELLS / 2);
        row0_q <= $signed({2'b00, qy_q}) - PW'(cogu_pkg::WINDOW_CELLS / 2);
      end
      cogu_pkg::ST_OFS1: sx_q <= $signed({2'b00, rx_q, 1'b0}) + 18'(t_ofs >>> 13);
      cogu_pkg::ST_OFS2: acc_q <= ACC_W'(ox_q) * ACC_W'(s_s);
      cogu_pkg::ST_OFS3: sy_q <= $signed({2'b00, ry_q, 1'b0}) + 18'(t_ofs >>> 13);
      cogu_pkg::ST_SQ0: begin
        free2_q <= (fr > 0) ? 34'(34'(fr) * 34'(fr)) : '0;
        wi_q    <= '0;
        wj_q    <= '0;
        cnt_q   <= '0;
        off_q   <= 1'b0;
      end
      cogu_pkg::ST_SQ1: occ2_q <= 34'(34'(oc) * 34'(oc));
      cogu_pkg::ST_CELL: begin
        dx_q   <= $signed(DX_W'(cen_x)) - DX_W'(sx_q);
        dy_q   <= $signed(DX_W'(cen_y)) - DX_W'(sy_q);
        addr_q <= rd_addr;
        if (!in_grid) off_q <= 1'b1;
      end
      cogu_pkg::ST_VEC:  zero_q <= dzero;
      cogu_pkg::ST_BEAR: sq_q <= cogu_pkg::SQ_W'(dx_q * dx_q);
      cogu_pkg::ST_DIST: d2_q <= cogu_pkg::D2_W'(sq_q) +
                                 cogu_pkg::D2_W'(cogu_pkg::SQ_W'(dy_q * dy_q));
      cogu_pkg::ST_UPD:  if (chg && cnt_q != 7'd127) cnt_q <= cnt_q + 1'b1;
      cogu_pkg::ST_NEXT: begin
        if (wj_q == WW'(cogu_pkg::WINDOW_CELLS - 1)) begin
          wj_q <= '0;
          wi_q <= wi_q + 1'b1;
        end else begin
          wj_q <= wj_q + 1'b1;
        end
      end
      default: ;
    endcase

    if (state_q == cogu_pkg::ST_DONE && out_free) begin
      out_q.cell_value    <= (func_q && rdok_q) ? $signed(rdata) : 16'sd0;
      out_q.cells_updated <= func_q ? 7'd0 : cnt_q;
      out_q.off_grid      <= func_q ? !rdok_q : off_q;
    end
  end

  cogu_ram #(
    .WIDTH(16),
    .DEPTH(cogu_pkg::MEM_DEPTH)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_addr),
    .wdata_i((state_q == cogu_pkg::ST_CLR) ? 16'd0 : sat),
    .re_i   (ram_re),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  cogu_cordic u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (creq),
    .rsp_o (crsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/sv/occupancy_grid_log_odds_update_core_test.sv =====
// Testbench for the log-odds occupancy grid update core: it drives items and checks results
// against its own grid model. Depends on cogu_pkg and the core's RTL.
module occupancy_grid_log_odds_update_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint ATAN_Z [16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                                     652, 326, 163, 81, 41, 20, 10, 5};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [2:0]          cfg_idx_i = '0;
  logic [15:0]         cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  cogu_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  cogu_pkg::out_item_t out_data_o;

  occupancy_grid_log_odds_update_core uut (.*);

  always #2 clk_i = ~clk_i;

  logic signed [15:0] grid_model [cogu_pkg::GRID_CELLS*cogu_pkg::GRID_CELLS];
  longint pose_x, pose_y, heading, ofs_x, ofs_y, cell_mm, wall_mm, beam_tol;
  cogu_pkg::in_item_t  pending_items [$];
  cogu_pkg::out_item_t expected_results [$];
  int     mismatches = 0;
  longint cycles = 0;

  function automatic void rotate_unit(input longint a, output longint c, output longint s);
    longint x, y, z, tx, ty;
    x = cogu_pkg::INV_GAIN_Q14;
    y = 0;
    z = (a & 16383) * 16;
    for (int i = 0; i < 16; i++) begin
      tx = x >>> i;
      ty = y >>> i;
      if (z >= 0) begin
        x -= ty; y += tx; z -= ATAN_Z[i];
      end else begin
        x += ty; y -= tx; z += ATAN_Z[i];
      end
    end
    case ((a >> 14) & 3)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint cell_bearing(input longint dx, input longint dy);
    longint x, y, z, tx, ty;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 4096;
    y = dy * 4096;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = cogu_pkg::HALF_TURN_Z;
    end
    for (int i = 0; i < 16; i++) begin
      tx = x >>> i;
      ty = y >>> i;
      if (y > 0) begin
        x += ty; y -= tx; z += ATAN_Z[i];
      end else begin
        x -= ty; y += tx; z -= ATAN_Z[i];
      end
    end
    return ((z + 8) >>> 4) & 65535;
  endfunction

  function automatic cogu_pkg::out_item_t apply_item(input cogu_pkg::in_item_t it);
    cogu_pkg::out_item_t r;
    longint beam, cs, c, s, sx, sy, fr, oc, free2, occ2, col0, row0;
    longint dx, dy, diff, mag, d2, v, rng;
    int idx;
    r = '0;
    if (it.func) begin
      r.cell_value = grid_model[int'(it.cell_y) * cogu_pkg::GRID_CELLS + int'(it.cell_x)];
      return r;
    end
    rng = longint'(it.range_mm);
    beam = (heading + longint'(it.scan_bearing)) & 65535;
    cs = (cell_mm != 0) ? cell_mm : 1;
    rotate_unit(heading, c, s);
    sx = 2 * pose_x + ((ofs_x * c - ofs_y * s + 4096) >>> 13);
    sy = 2 * pose_y + ((ofs_x * s + ofs_y * c + 4096) >>> 13);
    fr = 2 * rng - wall_mm;
    oc = 2 * rng + wall_mm;
    free2 = (fr > 0) ? fr * fr : 0;
    occ2 = oc * oc;
    col0 = pose_x / cs - cogu_pkg::WINDOW_CELLS / 2;
    row0 = pose_y / cs - cogu_pkg::WINDOW_CELLS / 2;
    for (longint row = row0; row < row0 + cogu_pkg::WINDOW_CELLS; row++) begin
      for (longint col = col0; col < col0 + cogu_pkg::WINDOW_CELLS; col++) begin
        if (row < 0 || col < 0 || row >= cogu_pkg::GRID_CELLS ||
            col >= cogu_pkg::GRID_CELLS) begin
          r.off_grid = 1'b1;
          continue;
        end
        dx = (2 * col + 1) * cs - sx;
        dy = (2 * row + 1) * cs - sy;
        diff = (cell_bearing(dx, dy) - beam) & 65535;
        mag = (diff >= 32768) ? 65536 - diff : diff;
        if (mag >= beam_tol) continue;
        d2 = dx * dx + dy * dy;
        idx = int'(row * cogu_pkg::GRID_CELLS + col);
        if (d2 < free2) v = grid_model[idx] + longint'(cogu_pkg::LOG_FREE);
        else if (d2 < occ2) v = grid_model[idx] + longint'(cogu_pkg::LOG_OCC);
        else continue;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        if (v != grid_model[idx]) begin
          grid_model[idx] = v[15:0];
          if (r.cells_updated != 7'd127) r.cells_updated++;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatches++;
  endtask

  task automatic add_item(input cogu_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    logic               next_valid;
    cogu_pkg::in_item_t next_data;
    next_valid = in_valid_i;
    next_data = in_data_i;
    if (in_valid_i && in_ready_o) begin
      expected_results.insert(expected_results.size(), apply_item(in_data_i));
      next_valid = 1'b0;
    end
    if (!next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() != 0) begin
        next_data = pending_items.pop_front();
        next_valid = 1'b1;
        if (burst_left == 0) begin
          burst_left = int'($urandom_range(1, 12));
        end else begin
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 30));
        end
      end
    end
    in_valid_i <= next_valid;
    in_data_i <= next_data;
  end

  // Receiver: alternates between always ready, random stalls and long stalls.
  int stall_left = 0;
  always @(posedge clk_i) begin
    logic next_ready;
    int   mode;
    mode = int'((cycles / 3000) % 3);
    next_ready = 1'b1;
    if (stall_left > 0) begin
      stall_left--;
      next_ready = 1'b0;
    end else if (mode == 1) begin
      next_ready = 1'($urandom_range(0, 1));
    end else if (mode == 2 && $urandom_range(0, 7) == 0) begin
      stall_left = int'($urandom_range(1, 60));
      next_ready = 1'b0;
    end
    out_ready_i <= next_ready;
  end

  always @(posedge clk_i) begin
    cogu_pkg::out_item_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.cell_value !== want.cell_value)
          report_mismatch("cell_value", out_data_o.cell_value, want.cell_value);
        if (out_data_o.cells_updated !== want.cells_updated)
          report_mismatch("cells_updated", out_data_o.cells_updated, want.cells_updated);
        if (out_data_o.off_grid !== want.off_grid)
          report_mismatch("off_grid", out_data_o.off_grid, want.off_grid);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input longint val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[15:0];
    case (idx)
      cogu_pkg::REG_ROBOT_X:   pose_x = val & 32767;
      cogu_pkg::REG_ROBOT_Y:   pose_y = val & 32767;
      cogu_pkg::REG_HEADING:   heading = val & 65535;
      cogu_pkg::REG_OFFSET_X:  ofs_x = longint'(signed'(val[11:0]));
      cogu_pkg::REG_OFFSET_Y:  ofs_y = longint'(signed'(val[11:0]));
      cogu_pkg::REG_CELL_SIZE: cell_mm = val & 1023;
      cogu_pkg::REG_WALL:      wall_mm = val & 1023;
      default:                 beam_tol = val & 16383;
    endcase
  endtask

  task automatic write_all(input longint rx, ry, hd, ox, oy, cs, wl, tl);
    write_reg(cogu_pkg::REG_ROBOT_X, rx);
    write_reg(cogu_pkg::REG_ROBOT_Y, ry);
    write_reg(cogu_pkg::REG_HEADING, hd);
    write_reg(cogu_pkg::REG_OFFSET_X, ox);
    write_reg(cogu_pkg::REG_OFFSET_Y, oy);
    write_reg(cogu_pkg::REG_CELL_SIZE, cs);
    write_reg(cogu_pkg::REG_WALL, wl);
    write_reg(cogu_pkg::REG_TOL, tl);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic cogu_pkg::in_item_t scan_item(input longint rng, input longint brg);
    cogu_pkg::in_item_t it;
    it = '0;
    it.range_mm = rng[13:0];
    it.scan_bearing = brg[15:0];
    it.cell_x = 7'($urandom());
    it.cell_y = 7'($urandom());
    return it;
  endfunction

  function automatic cogu_pkg::in_item_t read_item(input int cx, input int cy);
    cogu_pkg::in_item_t it;
    it = '0;
    it.func = 1'b1;
    it.range_mm = 14'($urandom());
    it.scan_bearing = 16'($urandom());
    it.cell_x = 7'(cx);
    it.cell_y = 7'(cy);
    return it;
  endfunction

  task automatic random_items(input int n);
    int cx, cy;
    for (int k = 0; k < n; k++) begin
      cx = int'(pose_x / ((cell_mm != 0) ? cell_mm : 1)) + int'($urandom_range(0, 10)) - 5;
      cy = int'(pose_y / ((cell_mm != 0) ? cell_mm : 1)) + int'($urandom_range(0, 10)) - 5;
      if ($urandom_range(0, 9) < 5)
        add_item(scan_item(longint'($urandom_range(0, 16383)), longint'($urandom())));
      else if ($urandom_range(0, 1) == 0 && cx >= 0 && cy >= 0 &&
               cx < cogu_pkg::GRID_CELLS && cy < cogu_pkg::GRID_CELLS)
        add_item(read_item(cx, cy));
      else
        add_item(read_item(int'($urandom_range(0, 127)), int'($urandom_range(0, 127))));
    end
  endtask

  initial begin
    longint rx, ry, cs;
    foreach (grid_model[i]) grid_model[i] = '0;
    pose_x = 50; pose_y = 50; heading = 16384; ofs_x = 0; ofs_y = 100;
    cell_mm = 100; wall_mm = 50; beam_tol = 728;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_item(read_item(0, 0));
    add_item(read_item(127, 127));
    add_item(read_item(127, 0));
    add_item(scan_item(0, 0));
    add_item(scan_item(16383, 65535));
    add_item(scan_item(300, 49152));
    add_item(scan_item(150, 0));
    add_item(scan_item(400, 32768));
    add_item(read_item(0, 1));
    add_item(read_item(0, 3));
    drain();

    // Sensor exactly on a cell centre, zero wall, wide beam.
    write_all(150, 150, 0, 0, 0, 100, 0, 8192);
    add_item(scan_item(250, 8192));
    add_item(scan_item(16383, 0));
    add_item(read_item(1, 1));
    add_item(read_item(2, 2));
    drain();

    // Zero cell size, zero tolerance, extreme offsets and a far pose.
    write_all(3, 7, 65535, 2048, 2047, 0, 1000, 0);
    add_item(scan_item(100, 0));
    drain();
    write_all(32767, 32767, 32768, 4095, 2048, 1023, 1023, 16383);
    add_item(scan_item(5000, 40000));
    add_item(read_item(127, 127));
    drain();

    // A small window on the grid corner, hit over and over until cells saturate.
    write_all(0, 0, 8192, 0, 0, 1000, 0, 8192);
    for (int k = 0; k < 160; k++) begin
      add_item(scan_item(longint'(16383 - (k % 3)), longint'($urandom_range(0, 2000))));
      if (k % 20 == 0) add_item(read_item(1, 1));
    end
    add_item(read_item(0, 0));
    add_item(read_item(2, 3));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      cs = longint'($urandom_range(10, 300));
      rx = longint'($urandom_range(0, 32'(128 * cs)));
      ry = longint'($urandom_range(0, 32'(128 * cs)));
      write_all(rx, ry, longint'($urandom()), longint'($urandom_range(0, 4095)),
                longint'($urandom_range(0, 4095)), cs, longint'($urandom_range(0, 1000)),
                longint'($urandom_range(0, 8192)));
      random_items(30);
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== occupancy_grid_log_odds_update_core.f =====
hdl/cogu_pkg.sv
hdl/cogu_ram.sv
hdl/cogu_cordic.sv
hdl/occupancy_grid_log_odds_update_core.sv
tb/sv/occupancy_grid_log_odds_update_core_test.sv
